/* rtl/clock_slot_allocator_macros.svh */
// Assertion macros shared by the clock slot allocator RTL.
`ifndef CLOCK_SLOT_ALLOCATOR_MACROS_SVH
`define CLOCK_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_slot_allocator: assertion failed");

// Next-cycle implication, disabled during reset.
`define CSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_slot_allocator: assertion failed");

`endif

/* rtl/csa_pkg.sv */
// Types and codes shared by the clock slot allocator.
`timescale 1ns / 1ps

package csa_pkg;

    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;
    localparam int POS_W  = 7;

    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;

    // One entry of the mark RAM.
    typedef struct packed {
        logic busy;
        logic refd;
    } t_marks;

endpackage

/* rtl/csa_mark_ram.sv */
// Busy/referenced mark RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module csa_mark_ram
    import csa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_marks        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_marks        o_rdata
);

    t_marks r_mem [DEPTH];
    t_marks r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/clock_slot_allocator.sv */
// Top level: clock (second chance) slot allocator for a square tile atlas.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over the mark RAM, with
// o_in_ready low. An allocate beat probes k slots, where k runs from 1 to
// 2*SLOTS: one probe per cycle, set by the single read port of the mark RAM,
// pipelined so the next slot is read while the current one is judged. One
// beat is worked on at a time; the result sits in an output register, so the
// next beat is taken while it waits.
// Tile position is tracked as column/row next to the hand, so x and y need
// only a multiply by TILE.
module clock_slot_allocator
    import csa_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int ROW_SLOTS = 8,
    parameter int TILE      = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_slot_id,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_pos_x,
    output logic [POS_W-1:0]  o_pos_y
);

`include "clock_slot_allocator_macros.svh"

    localparam int AW    = $clog2(SLOTS);
    localparam int PW    = $clog2(2 * SLOTS);
    localparam int CW    = $clog2(ROW_SLOTS);
    localparam int ROWS  = (SLOTS + ROW_SLOTS - 1) / ROW_SLOTS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [PW-1:0] PROBE_LAST = PW'(2 * SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_REL   = 5'b01000,
        S_POST  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_hand, n_hand;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] r_probes, n_probes;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_rel_ok, n_rel_ok;
    logic [AW-1:0] r_rel_addr, n_rel_addr;

    logic [SLOT_W-1:0] r_res_id, n_res_id;
    logic [STAT_W-1:0] r_res_stat, n_res_stat;
    logic [POS_W-1:0]  r_res_x, n_res_x;
    logic [POS_W-1:0]  r_res_y, n_res_y;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_id;
    logic [STAT_W-1:0] r_out_stat;
    logic [POS_W-1:0]  r_out_x;
    logic [POS_W-1:0]  r_out_y;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_marks        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_marks        mem_rdata;

    logic          in_acc;
    logic          load_out;
    logic          hand_last;
    logic          col_last;
    logic [AW-1:0] hand_nx;
    logic [CW-1:0] col_nx;
    logic [RW-1:0] row_nx;
    logic [31:0]   slot_wide;
    logic          slot_in_range;
    logic [AW-1:0] slot_addr;

    csa_mark_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign load_out      = (r_state == S_POST) && (!r_out_valid || i_out_ready);

    assign slot_wide     = 32'(i_slot);
    assign slot_in_range = slot_wide < 32'(SLOTS);
    assign slot_addr     = slot_wide[AW-1:0];

    // Hand advance with column/row kept in step.
    assign hand_last = (32'(r_hand) == 32'(SLOTS - 1));
    assign col_last  = (32'(r_col) == 32'(ROW_SLOTS - 1));
    assign hand_nx   = hand_last ? '0 : r_hand + 1'b1;
    assign col_nx    = (hand_last || col_last) ? '0 : r_col + 1'b1;
    assign row_nx    = hand_last ? '0 : (col_last ? r_row + 1'b1 : r_row);

    always_comb begin
        n_state    = r_state;
        n_hand     = r_hand;
        n_col      = r_col;
        n_row      = r_row;
        n_probes   = r_probes;
        n_clr      = r_clr;
        n_rel_ok   = r_rel_ok;
        n_rel_addr = r_rel_addr;
        n_res_id   = r_res_id;
        n_res_stat = r_res_stat;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;
        mem_we     = 1'b0;
        mem_waddr  = r_hand;
        mem_wdata  = '{busy: 1'b0, refd: 1'b0};
        mem_raddr  = r_hand;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                // slot 0 is reserved from reset on
                mem_wdata = '{busy: (r_clr == '0), refd: 1'b0};
                if (32'(r_clr) == 32'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FN_ALLOC) begin
                        mem_raddr = r_hand;
                        n_probes  = '0;
                        n_state   = S_PROBE;
                    end else begin
                        mem_raddr  = slot_addr;
                        n_rel_ok   = slot_in_range && (i_slot != '0);
                        n_rel_addr = slot_addr;
                        n_state    = S_REL;
                    end
                end
            end
            S_PROBE: begin
                // rdata holds the marks of r_hand; fetch the next slot meanwhile
                mem_raddr = hand_nx;
                mem_we    = 1'b1;
                mem_waddr = r_hand;
                n_hand    = hand_nx;
                n_col     = col_nx;
                n_row     = row_nx;
                if (!mem_rdata.busy && !mem_rdata.refd) begin
                    mem_wdata  = '{busy: 1'b1, refd: 1'b1};
                    n_res_id   = SLOT_W'(r_hand);
                    n_res_stat = ST_OK;
                    n_res_x    = POS_W'(32'(r_col) * TILE);
                    n_res_y    = POS_W'(32'(r_row) * TILE);
                    n_state    = S_POST;
                end else begin
                    mem_wdata = '{busy: mem_rdata.busy, refd: 1'b0};
                    if (r_probes == PROBE_LAST) begin
                        n_res_id   = '0;
                        n_res_stat = ST_FULL;
                        n_res_x    = '0;
                        n_res_y    = '0;
                        n_state    = S_POST;
                    end else begin
                        n_probes = r_probes + 1'b1;
                    end
                end
            end
            S_REL: begin
                n_res_id = '0;
                n_res_x  = '0;
                n_res_y  = '0;
                if (r_rel_ok && mem_rdata.busy) begin
                    // mark stays: freed slot still gets its second chance
                    mem_we     = 1'b1;
                    mem_waddr  = r_rel_addr;
                    mem_wdata  = '{busy: 1'b0, refd: mem_rdata.refd};
                    n_res_stat = ST_OK;
                end else begin
                    n_res_stat = ST_BAD_RELEASE;
                end
                n_state = S_POST;
            end
            S_POST: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_hand      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_probes    <= '0;
            r_clr       <= '0;
            r_rel_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hand   <= n_hand;
            r_col    <= n_col;
            r_row    <= n_row;
            r_probes <= n_probes;
            r_clr    <= n_clr;
            r_rel_ok <= n_rel_ok;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel_addr <= n_rel_addr;
        r_res_id   <= n_res_id;
        r_res_stat <= n_res_stat;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        if (load_out) begin
            r_out_id   <= r_res_id;
            r_out_stat <= r_res_stat;
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot_id   = r_out_id;
    assign o_status    = r_out_stat;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;

    `CSA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), (o_slot_id == '0) && (o_pos_x == '0) && (o_pos_y == '0))
    `CSA_ASSERT_NEXT(a_accept_to_work, i_clk, i_rst_n, in_acc, (r_state == S_PROBE) || (r_state == S_REL))
    `CSA_ASSERT_IMPL(a_probe_bound, i_clk, i_rst_n, r_state == S_PROBE, r_probes <= PROBE_LAST)
    `CSA_ASSERT_IMPL(a_hand_range, i_clk, i_rst_n, 1'b1, 32'(r_hand) < 32'(SLOTS))

endmodule
